// File: hw/rtl/rde_pkg.sv
`timescale 1ns / 1ps

package rde_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 32;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = RADIX_W;
  localparam int CHAR_W      = 7;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W      = $clog2(MAX_DIGITS);
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_ZERO        = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_LETTER_BASE = CHAR_W'(55);
  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT   = DIGIT_W'(10);

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
  } div_status_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(d);
    if (d < DECIMAL_LIMIT) begin
      digit_to_char = ext + CHAR_ZERO;
    end else begin
      digit_to_char = ext + CHAR_LETTER_BASE;
    end
  endfunction

endpackage

// File: hw/rtl/rde_ram.sv
`timescale 1ns / 1ps

module rde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/rde_div.sv
`timescale 1ns / 1ps

module rde_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rde_pkg::div_ctrl_t                ctrl,
  input  logic [rde_pkg::VALUE_WIDTH-1:0]   dividend,
  input  logic [rde_pkg::RADIX_W-1:0]       divisor,
  output logic [rde_pkg::VALUE_WIDTH-1:0]   quotient,
  output logic [rde_pkg::DIGIT_W-1:0]       remainder,
  output rde_pkg::div_status_t              status
);

  import rde_pkg::*;

  logic [VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [RADIX_W-1:0]     rem_r, rem_nxt;
  logic [RADIX_W-1:0]     div_r, div_nxt;
  logic [BIT_CNT_W-1:0]   bit_r, bit_nxt;
  logic                   run_r, run_nxt;
  logic                   done_r, done_nxt;
  logic [RADIX_W:0]       trial;
  logic [RADIX_W:0]       diff;
  logic                   fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_r, q_r[VALUE_WIDTH-1]};
    fits  = trial >= {1'b0, div_r};
    diff  = trial - {1'b0, div_r};
  end

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    bit_nxt  = bit_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (ctrl.start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      div_nxt = divisor;
      bit_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      q_nxt   = {q_r[VALUE_WIDTH-2:0], fits};
      rem_nxt = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      bit_nxt = bit_r + BIT_CNT_W'(1);
      if (bit_r == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    bit_r <= bit_nxt;
  end

  assign quotient    = q_r;
  assign remainder   = rem_r;
  assign status.done = done_r;

endmodule

// File: hw/rtl/radix_digit_emitter.sv
`timescale 1ns / 1ps
// a value of D digits is built by bit-serial division, one digit at a time (one
// quotient bit per cycle over 32 bits), then a read of the stored digits, then
// the D characters on consecutive cycles
// throughput: one request at a time, the next accepted once busy falls
// a zero value gives its single '0' in the cycle after acceptance
// reset (synchronous, active low) idles the block and sets the base to ten

module radix_digit_emitter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rde_pkg::RADIX_W-1:0]        cfg_data,
  input  logic                               start,
  output logic                               busy,
  input  logic [rde_pkg::VALUE_WIDTH-1:0]    in_value_in,
  output logic                               out_valid,
  output logic [rde_pkg::CHAR_W-1:0]         out_digit_char,
  output logic                               out_is_last
);

  import rde_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_READ = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_ZERO = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [RADIX_W-1:0]   radix_r, radix_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]    idx_r, idx_nxt;

  div_ctrl_t            div_ctrl;
  div_status_t          div_stat;
  logic [VALUE_WIDTH-1:0] dividend;
  logic [VALUE_WIDTH-1:0] quotient;
  logic [DIGIT_W-1:0]   remainder;
  logic                 accept;
  logic                 more;
  logic                 ram_we;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [DIGIT_W-1:0]   ram_rdata;

  rde_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (div_ctrl),
    .dividend  (dividend),
    .divisor   (radix_r),
    .quotient  (quotient),
    .remainder (remainder),
    .status    (div_stat)
  );

  rde_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (remainder),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign more   = (quotient != '0) && (cnt_r != CNT_W'(MAX_DIGITS - 1));

  // invalid bases are dropped
  always_comb begin
    radix_nxt = radix_r;
    if (cfg_we && (cfg_data >= RADIX_MIN) && (cfg_data <= RADIX_MAX)) begin
      radix_nxt = cfg_data;
    end
  end

  always_comb begin
    dividend       = (state_r == ST_IDLE) ? in_value_in : quotient;
    div_ctrl.start = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = idx_r - ADDR_W'(1);
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          if (in_value_in == '0) begin
            state_nxt = ST_ZERO;
          end else begin
            div_ctrl.start = 1'b1;
            state_nxt      = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          ram_we  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (more) begin
            div_ctrl.start = 1'b1;
          end else begin
            idx_nxt   = cnt_r[ADDR_W-1:0];
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (idx_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          // prefetch the next lower digit
          ram_re  = 1'b1;
          idx_nxt = idx_r - ADDR_W'(1);
        end
      end
      ST_ZERO: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      radix_r <= RADIX_RESET;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      radix_r <= radix_nxt;
      cnt_r   <= cnt_nxt;
    end
    idx_r <= idx_nxt;
  end

  assign out_valid      = (state_r == ST_EMIT) || (state_r == ST_ZERO);
  assign out_digit_char = (state_r == ST_ZERO) ? CHAR_ZERO : digit_to_char(ram_rdata);
  assign out_is_last    = (state_r == ST_ZERO) || (idx_r == '0);

endmodule
